### rtl/ahs_pkg.sv
// shared types, constants and constant tables of the additive harmonic sine sum
package ahs_pkg;

  // input item kinds carried on tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register map, selected by paddr bit 2
  localparam logic REG_DAMP  = 1'b0;
  localparam logic REG_PHASE = 1'b1;

  // field widths
  localparam int CMD_W   = 1;
  localparam int HIDX_W  = 4;
  localparam int AMP_W   = 16;
  localparam int PHASE_W = 16;
  localparam int DAMP_W  = 10;
  localparam int POFS_W  = 15;
  localparam int WAVE_W  = 20;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // fixed-point constants
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [9:0]  DAMP_FULL   = 10'd640;
  localparam logic signed [AMP_W-1:0] AMP_RESET_FIRST = 16'sd32767;
  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_AMP,
    ST_HMUL,
    ST_HONE,
    ST_HREC,
    ST_HCHK,
    ST_HFIX,
    ST_SQ_MUL,
    ST_SQ_WB,
    ST_WGT,
    ST_WMUL,
    ST_WRND,
    ST_XMUL,
    ST_X2MUL,
    ST_X2WB,
    ST_SOUT,
    ST_SRND,
    ST_TMUL,
    ST_TACC,
    ST_NEXT,
    ST_FIN
  } ahs_state_t;

  // divisor of one horner step: term number for the exponential,
  // (2j)(2j+1) for the sine
  function automatic logic [7:0] horner_div(input logic sine, input logic [3:0] step);
    logic [7:0] d;
    d = 8'd1;
    if (sine) begin
      case (step)
        4'd6:    d = 8'd156;
        4'd5:    d = 8'd110;
        4'd4:    d = 8'd72;
        4'd3:    d = 8'd42;
        4'd2:    d = 8'd20;
        4'd1:    d = 8'd6;
        default: d = 8'd1;
      endcase
    end else begin
      d = {4'd0, step};
    end
    return d;
  endfunction

  // ceil(2^32 / divisor); quotient estimate is exact or one too high
  function automatic logic [31:0] horner_recip(input logic sine, input logic [3:0] step);
    logic [7:0] d;
    logic [31:0] m;
    d = horner_div(sine, step);
    case (d)
      8'd2:    m = 32'd2147483648;
      8'd3:    m = 32'd1431655766;
      8'd4:    m = 32'd1073741824;
      8'd5:    m = 32'd858993460;
      8'd6:    m = 32'd715827883;
      8'd7:    m = 32'd613566757;
      8'd8:    m = 32'd536870912;
      8'd20:   m = 32'd214748365;
      8'd42:   m = 32'd102261127;
      8'd72:   m = 32'd59652324;
      8'd110:  m = 32'd39045158;
      8'd156:  m = 32'd27531842;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/ahs_ram.sv
// generic single-write single-read ram with registered read data
module ahs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/additive_harmonic_sine_sum.sv
// top level: additive oscillator summing damped harmonic sines of a phase word
//
//  port group  direction  contents
//  in_*        slave      tuser: cmd; tdata: harmonic_index, amplitude, phase_code
//  out_*       master     tdata: wave_sum
//  cfg_*       apb        0x0 damp_setting, 0x4 phase_offset
//
// an amplitude write is taken in idle; a sample visits every harmonic and skips the
// series for each harmonic whose amplitude is not positive; the exp and sine series
// of the others run on one shared 32x32 multiplier under the sequencer.
// rst_n is synchronous; the amplitude store reads as its reset values until written.
// in_tready is high only in idle; one finished result waits in the output register
// and a new item is accepted meanwhile; a further result waits in the last state.
module additive_harmonic_sine_sum
  import ahs_pkg::*;
#(
  parameter int HARMONICS       = 16,
  parameter int SINE_INDEX_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input transactions
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,    // [3:0] harmonic_index, [19:4] amplitude,
                                               // [35:20] phase_code, [39:36] zero
  input  logic [CMD_W-1:0]        in_tuser,    // [0] cmd
  // result transactions
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,   // [19:0] wave_sum, [23:20] zero
  // configuration
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int KW    = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int SHIFT = 15 - SINE_INDEX_BITS;
  localparam int QBITS = SINE_INDEX_BITS - 2;
  localparam int SUM_W = 32 + KW;

  // unpacked input fields
  logic                      in_cmd;
  logic [HIDX_W-1:0]         in_harmonic_index;
  logic signed [AMP_W-1:0]   in_amplitude;
  logic signed [PHASE_W-1:0] in_phase_code;

  assign in_cmd            = in_tuser[0];
  assign in_harmonic_index = in_tdata[3:0];
  assign in_amplitude      = in_tdata[19:4];
  assign in_phase_code     = in_tdata[35:20];

  // state
  ahs_state_t state_r, state_nxt;
  logic [DAMP_W-1:0]  damp_r, damp_nxt;
  logic [POFS_W-1:0]  pofs_r, pofs_nxt;
  logic [HARMONICS-1:0] vld_r, vld_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WAVE_W-1:0]  out_sum_r, out_sum_nxt;

  logic [14:0]        p_r, p_nxt;
  logic [14:0]        hp_r, hp_nxt;
  logic [9:0]         d64_r, d64_nxt;
  logic [15:0]        t_r, t_nxt;
  logic [14:0]        amp_r, amp_nxt;
  logic               hsel_r, hsel_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [30:0]        poly_r, poly_nxt;
  logic [31:0]        n_r, n_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [15:0]        w_r, w_nxt;
  logic [15:0]        wa_r, wa_nxt;
  logic [30:0]        z_r, z_nxt;
  logic               neg_r, neg_nxt;
  logic [30:0]        x_r, x_nxt;
  logic [31:0]        x2_r, x2_nxt;
  logic [16:0]        v_r, v_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [63:0]        prod_r, prod_nxt;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

  // amplitude store
  logic                ram_we, ram_re;
  logic [KW-1:0]       ram_waddr;
  logic [AMP_W-1:0]    ram_rdata;
  logic signed [AMP_W-1:0] amp_cur;

  ahs_ram #(
    .WIDTH (AMP_W),
    .DEPTH (HARMONICS)
  ) u_amp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_amplitude),
    .re    (ram_re),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  assign ram_waddr = KW'(in_harmonic_index);

  // never-written entries read as reset values
  always_comb begin
    if (vld_r[k_r]) begin
      amp_cur = $signed(ram_rdata);
    end else if (k_r == KW'(0)) begin
      amp_cur = AMP_RESET_FIRST;
    end else begin
      amp_cur = '0;
    end
  end

  // handshakes and configuration port
  logic in_acc, cfg_wr;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_PHASE) ? {17'd0, pofs_r} : {22'd0, damp_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-WAVE_W){1'b0}}, out_sum_r};

  // sample setup values
  logic [14:0] phase_sum;
  logic [9:0]  damp_clamped;
  assign phase_sum    = in_phase_code[14:0] + pofs_r;
  assign damp_clamped = (damp_r > DAMP_FULL) ? DAMP_FULL : damp_r;

  // sine index, quadrant fold and first-quadrant angle
  logic [15:0]                hp_rnd;
  logic [SINE_INDEX_BITS-1:0] sidx;
  logic [1:0]                 quad;
  logic [QBITS-1:0]           srem;
  logic [QBITS:0]             rfold;
  assign hp_rnd = {1'b0, hp_r} + 16'(1 << (SHIFT - 1));
  assign sidx   = hp_rnd[SHIFT +: SINE_INDEX_BITS];
  assign quad   = sidx[SINE_INDEX_BITS-1 -: 2];
  assign srem   = sidx[QBITS-1:0];
  assign rfold  = quad[0] ? ((QBITS+1)'(1 << QBITS) - {1'b0, srem}) : {1'b0, srem};

  // horner divisor and quotient correction
  logic [7:0]  hdiv;
  logic [31:0] hrecip;
  logic        q_high;
  logic [31:0] q_fix;
  assign hdiv   = horner_div(hsel_r, step_r);
  assign hrecip = horner_recip(hsel_r, step_r);
  assign q_high = (prod_r > {32'd0, n_r});
  assign q_fix  = q_r - {31'd0, q_high};

  // rounding helpers
  logic [63:0] sq_rnd;
  logic [31:0] wgt_rnd;
  logic [31:0] wa_rnd;
  logic [32:0] v_rnd;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] fin_rnd;
  logic signed [SUM_W-1:0] fin_val;
  logic [WAVE_W-1:0]       fin_sat;
  assign sq_rnd  = prod_r + 64'h2000_0000;
  assign wgt_rnd = {1'b0, poly_r} + 32'd16384;
  assign wa_rnd  = prod_r[31:0] + 32'd16384;
  assign v_rnd   = {1'b0, prod_r[61:30]} + 33'd16384;
  assign term    = $signed({{(SUM_W-33){1'b0}}, prod_r[32:0]});
  assign fin_rnd = sum_r + SUM_W'(16384);
  assign fin_val = fin_rnd >>> 15;

  // output saturation
  always_comb begin
    if (fin_val > SUM_W'(OUT_MAX)) begin
      fin_sat = WAVE_W'(OUT_MAX);
    end else if (fin_val < SUM_W'(OUT_MIN)) begin
      fin_sat = WAVE_W'(OUT_MIN);
    end else begin
      fin_sat = fin_val[WAVE_W-1:0];
    end
  end

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    damp_nxt      = damp_r;
    pofs_nxt      = pofs_r;
    vld_nxt       = vld_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sum_nxt   = out_sum_r;
    p_nxt         = p_r;
    hp_nxt        = hp_r;
    d64_nxt       = d64_r;
    t_nxt         = t_r;
    amp_nxt       = amp_r;
    hsel_nxt      = hsel_r;
    step_nxt      = step_r;
    poly_nxt      = poly_r;
    n_nxt         = n_r;
    q_nxt         = q_r;
    w_nxt         = w_r;
    wa_nxt        = wa_r;
    z_nxt         = z_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    v_nxt         = v_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // register writes
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_DAMP:  damp_nxt = cfg_pwdata[DAMP_W-1:0];
        REG_PHASE: pofs_nxt = cfg_pwdata[POFS_W-1:0];
        default:   damp_nxt = damp_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_WRITE) begin
            if (int'(in_harmonic_index) < HARMONICS) begin
              ram_we             = 1'b1;
              vld_nxt[ram_waddr] = 1'b1;
            end
          end else begin
            p_nxt     = phase_sum;
            hp_nxt    = phase_sum;
            d64_nxt   = DAMP_FULL - damp_clamped;
            t_nxt     = '0;
            k_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_AMP;
      end
      // only positive amplitudes contribute
      ST_AMP: begin
        if (!amp_cur[AMP_W-1] && (amp_cur != '0)) begin
          amp_nxt   = amp_cur[14:0];
          poly_nxt  = ONE_Q30;
          step_nxt  = 4'd8;
          hsel_nxt  = 1'b0;
          state_nxt = ST_HMUL;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      // horner step: operand times running polynomial
      ST_HMUL: begin
        mul_a    = hsel_r ? x2_r : {2'd0, t_r, 14'd0};
        mul_b    = {1'b0, poly_r};
        prod_nxt = mul_prod;
        if (!hsel_r && (step_r == 4'd1)) begin
          state_nxt = ST_HONE;
        end else begin
          state_nxt = ST_HREC;
        end
      end
      // last exp step divides by one
      ST_HONE: begin
        poly_nxt  = 31'({1'b0, ONE_Q30} - prod_r[61:30]);
        step_nxt  = 4'd5;
        state_nxt = ST_SQ_MUL;
      end
      // quotient estimate by reciprocal
      ST_HREC: begin
        n_nxt     = prod_r[61:30];
        mul_a     = prod_r[61:30];
        mul_b     = hrecip;
        prod_nxt  = mul_prod;
        state_nxt = ST_HCHK;
      end
      ST_HCHK: begin
        q_nxt     = prod_r[63:32];
        mul_a     = prod_r[63:32];
        mul_b     = {24'd0, hdiv};
        prod_nxt  = mul_prod;
        state_nxt = ST_HFIX;
      end
      ST_HFIX: begin
        poly_nxt = 31'({1'b0, ONE_Q30} - q_fix);
        if (hsel_r && (step_r == 4'd1)) begin
          state_nxt = ST_SOUT;
        end else begin
          step_nxt  = step_r - 4'd1;
          state_nxt = ST_HMUL;
        end
      end
      // five squarings of the exp series
      ST_SQ_MUL: begin
        mul_a     = {1'b0, poly_r};
        mul_b     = {1'b0, poly_r};
        prod_nxt  = mul_prod;
        state_nxt = ST_SQ_WB;
      end
      ST_SQ_WB: begin
        poly_nxt = sq_rnd[60:30];
        if (step_r == 4'd1) begin
          state_nxt = ST_WGT;
        end else begin
          step_nxt  = step_r - 4'd1;
          state_nxt = ST_SQ_MUL;
        end
      end
      // weight to q15 and weighted amplitude
      ST_WGT: begin
        w_nxt     = wgt_rnd[30:15];
        state_nxt = ST_WMUL;
      end
      ST_WMUL: begin
        mul_a     = {17'd0, amp_r};
        mul_b     = {16'd0, w_r};
        prod_nxt  = mul_prod;
        state_nxt = ST_WRND;
      end
      ST_WRND: begin
        wa_nxt    = wa_rnd[30:15];
        z_nxt     = {rfold, (30-QBITS)'(0)};
        neg_nxt   = quad[1];
        state_nxt = ST_XMUL;
      end
      // sine angle and its square
      ST_XMUL: begin
        mul_a     = {1'b0, z_r};
        mul_b     = {1'b0, HALF_PI_Q30};
        prod_nxt  = mul_prod;
        state_nxt = ST_X2MUL;
      end
      ST_X2MUL: begin
        x_nxt     = prod_r[60:30];
        mul_a     = {1'b0, prod_r[60:30]};
        mul_b     = {1'b0, prod_r[60:30]};
        prod_nxt  = mul_prod;
        state_nxt = ST_X2WB;
      end
      ST_X2WB: begin
        x2_nxt    = prod_r[61:30];
        poly_nxt  = ONE_Q30;
        step_nxt  = 4'd6;
        hsel_nxt  = 1'b1;
        state_nxt = ST_HMUL;
      end
      // sine value and term
      ST_SOUT: begin
        mul_a     = {1'b0, x_r};
        mul_b     = {1'b0, poly_r};
        prod_nxt  = mul_prod;
        state_nxt = ST_SRND;
      end
      ST_SRND: begin
        v_nxt     = v_rnd[31:15];
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        mul_a     = {16'd0, wa_r};
        mul_b     = {15'd0, v_r};
        prod_nxt  = mul_prod;
        state_nxt = ST_TACC;
      end
      ST_TACC: begin
        sum_nxt   = neg_r ? (sum_r - term) : (sum_r + term);
        state_nxt = ST_NEXT;
      end
      // advance harmonic, running products of k
      ST_NEXT: begin
        if (int'(k_r) == HARMONICS - 1) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + KW'(1);
          t_nxt     = t_r + {6'd0, d64_r};
          hp_nxt    = hp_r + p_r;
          state_nxt = ST_RD;
        end
      end
      // round, saturate and hand to the output register
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = fin_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      damp_r      <= '0;
      pofs_r      <= '0;
      vld_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      damp_r      <= damp_nxt;
      pofs_r      <= pofs_nxt;
      vld_r       <= vld_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
    p_r       <= p_nxt;
    hp_r      <= hp_nxt;
    d64_r     <= d64_nxt;
    t_r       <= t_nxt;
    amp_r     <= amp_nxt;
    hsel_r    <= hsel_nxt;
    step_r    <= step_nxt;
    poly_r    <= poly_nxt;
    n_r       <= n_nxt;
    q_r       <= q_nxt;
    w_r       <= w_nxt;
    wa_r      <= wa_nxt;
    z_r       <= z_nxt;
    neg_r     <= neg_nxt;
    x_r       <= x_nxt;
    x2_r      <= x2_nxt;
    v_r       <= v_nxt;
    sum_r     <= sum_nxt;
    prod_r    <= prod_nxt;
  end

  // a result appears only from the final state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result register loaded outside the final state");

  // reciprocal estimate is never more than one above the quotient
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HFIX) |-> (prod_r < ({32'd0, n_r} + {56'd0, hdiv})))
    else $error("quotient estimate off by more than one");

  // series operand stays at or below one
  a_poly_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HMUL || state_r == ST_SQ_MUL) |-> (poly_r <= ONE_Q30))
    else $error("series value above one");

  // harmonic counter stays inside the store
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (int'(k_r) < HARMONICS))
    else $error("harmonic counter out of range");

  // an amplitude write never starts the sequencer
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_WRITE) |=> (state_r == ST_IDLE))
    else $error("amplitude write left idle");

endmodule
